@@ rtl/core/sfmcp_pkg.sv @@
// Shared types and constants of the serial frame motor command parser.
package sfmcp_pkg;

    localparam int POS_W      = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_TOPIC = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TOPIC  = 1'd1;

    localparam logic [7:0] MOTOR_TOPIC_RST = 8'd100;
    localparam logic [7:0] STOP_TOPIC_RST  = 8'd11;

    localparam logic [7:0] SYNC1_BYTE = 8'hFF;
    localparam logic [7:0] SYNC2_BYTE = 8'hFE;
    localparam logic [7:0] COMMA_BYTE = 8'h2C;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    localparam logic [POS_W-1:0] LEN_BYTES     = 9'd2;
    localparam logic [POS_W-1:0] TOPIC_POS     = 9'd2;
    localparam logic [POS_W-1:0] HDR_BYTES     = 9'd4;
    localparam logic [POS_W-1:0] LEFT_DIR_POS  = 9'd8;
    localparam logic [POS_W-1:0] RIGHT_DIR_POS = 9'd10;
    localparam logic [POS_W-1:0] PWM_START_POS = 9'd12;

    localparam logic [1:0] EV_STOP      = 2'd0;
    localparam logic [1:0] EV_TOPIC_REQ = 2'd1;
    localparam logic [1:0] EV_MOTOR     = 2'd2;

    // store read kinds
    localparam logic [1:0] RK_NONE = 2'd0;
    localparam logic [1:0] RK_LDIR = 2'd1;
    localparam logic [1:0] RK_RDIR = 2'd2;
    localparam logic [1:0] RK_DIG  = 2'd3;

    typedef struct packed {
        logic       wp_clear;
        logic       wr_len;
        logic       wr_topic;
        logic       wr_msg;
        logic       out_load_short;
        logic       scan_init;
        logic [1:0] rd_kind;
        logic       out_load_motor;
    } t_cmd;

    typedef struct packed {
        logic byte_sync1;
        logic byte_sync2;
        logic len_done;
        logic topic_done;
        logic msg_last;
        logic len_zero;
        logic topic_motor;
        logic scan_done;
        logic out_valid;
    } t_status;

endpackage

@@ rtl/core/sfmcp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module sfmcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/sfmcp_dp.sv @@
// Datapath: frame store, header registers, PWM scan accumulators, result register.
module sfmcp_dp #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sfmcp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sfmcp_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic [7:0]                          i_rx_byte,
    input  sfmcp_pkg::t_cmd                     i_cmd,
    output sfmcp_pkg::t_status                  o_status,
    input  logic                                i_ev_ready,
    output logic                                o_ev_valid,
    output logic [1:0]                          o_event_kind,
    output logic [7:0]                          o_left_direction,
    output logic [7:0]                          o_right_direction,
    output logic [15:0]                         o_left_pwm,
    output logic [15:0]                         o_right_pwm
);

    import sfmcp_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam logic [POS_W:0] DEPTH_L = (POS_W + 1)'(BUFFER_DEPTH);

    logic [7:0]       r_motor_topic;
    logic [7:0]       r_stop_topic;
    logic [POS_W-1:0] r_wp;
    logic [7:0]       r_msg_len;
    logic [POS_W-1:0] r_msg_end;
    logic [7:0]       r_topic;
    logic [POS_W-1:0] r_pos;
    logic             r_left;
    logic [15:0]      r_lp;
    logic [15:0]      r_rp;
    logic [7:0]       r_ld;
    logic [7:0]       r_rd;
    logic [1:0]       r_rd_kind;
    logic             r_rd_inr;
    logic             r_out_valid;
    logic [1:0]       r_ev_kind;
    logic [7:0]       r_ev_ld;
    logic [7:0]       r_ev_rd;
    logic [15:0]      r_ev_lp;
    logic [15:0]      r_ev_rp;

    logic [POS_W-1:0] wp_inc;
    logic             msg_room;
    logic             wr_any;
    logic             ram_we;
    logic [POS_W-1:0] raddr_full;
    logic             raddr_inr;
    logic [7:0]       ram_q;
    logic [7:0]       rd_byte;
    logic [15:0]      acc;
    logic [15:0]      acc_next;
    logic             n_out_valid;

    assign wp_inc   = r_wp + 9'd1;
    assign msg_room = r_wp < r_msg_end;
    assign wr_any   = i_cmd.wr_len | i_cmd.wr_topic | (i_cmd.wr_msg & msg_room);
    assign ram_we   = wr_any & ({1'b0, r_wp} < DEPTH_L);

    always_comb begin
        case (i_cmd.rd_kind)
            RK_LDIR: raddr_full = LEFT_DIR_POS;
            RK_RDIR: raddr_full = RIGHT_DIR_POS;
            RK_DIG:  raddr_full = r_pos;
            default: raddr_full = r_pos;
        endcase
    end

    assign raddr_inr = {1'b0, raddr_full} < DEPTH_L;

    sfmcp_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (raddr_full[AW-1:0]),
        .o_rdata (ram_q)
    );

    // positions past the store read as zero
    assign rd_byte  = r_rd_inr ? ram_q : 8'h00;
    assign acc      = r_left ? r_lp : r_rp;
    assign acc_next = {acc[12:0], 3'b000} + {acc[14:0], 1'b0} + {8'h00, rd_byte}
                      - {8'h00, ASCII_ZERO};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_topic <= MOTOR_TOPIC_RST;
            r_stop_topic  <= STOP_TOPIC_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MOTOR_TOPIC: r_motor_topic <= i_cfg_wdata;
                CFG_STOP_TOPIC:  r_stop_topic  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_msg_len <= '0;
            r_msg_end <= '0;
            r_rd_kind <= RK_NONE;
        end else begin
            if (i_cmd.wp_clear) begin
                r_wp <= '0;
            end else if (wr_any) begin
                r_wp <= wp_inc;
            end
            if (i_cmd.wr_len && r_wp == '0) begin
                r_msg_len <= i_rx_byte;
            end
            if (i_cmd.wr_topic && wp_inc >= HDR_BYTES && r_msg_len != 8'd0) begin
                r_msg_end <= {1'b0, r_msg_len} + HDR_BYTES;
            end
            r_rd_kind <= i_cmd.rd_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_inr <= raddr_inr;
        if (i_cmd.wr_topic && r_wp == TOPIC_POS) begin
            r_topic <= i_rx_byte;
        end
        if (i_cmd.scan_init) begin
            r_pos  <= PWM_START_POS;
            r_left <= 1'b1;
            r_lp   <= '0;
            r_rp   <= '0;
        end else begin
            if (i_cmd.rd_kind == RK_DIG) begin
                r_pos <= r_pos + 9'd1;
            end
            case (r_rd_kind)
                RK_LDIR: r_ld <= rd_byte - ASCII_ZERO;
                RK_RDIR: r_rd <= rd_byte - ASCII_ZERO;
                RK_DIG: begin
                    if (r_left && rd_byte == COMMA_BYTE) begin
                        r_left <= 1'b0;
                    end else if (r_left) begin
                        r_lp <= acc_next;
                    end else begin
                        r_rp <= acc_next;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.out_load_short || i_cmd.out_load_motor) begin
            n_out_valid = 1'b1;
        end else if (i_ev_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load_short) begin
            r_ev_kind <= (r_topic == r_stop_topic) ? EV_STOP : EV_TOPIC_REQ;
            r_ev_ld   <= '0;
            r_ev_rd   <= '0;
            r_ev_lp   <= '0;
            r_ev_rp   <= '0;
        end else if (i_cmd.out_load_motor) begin
            r_ev_kind <= EV_MOTOR;
            r_ev_ld   <= r_ld;
            r_ev_rd   <= r_rd;
            r_ev_lp   <= r_lp;
            r_ev_rp   <= r_rp;
        end
    end

    assign o_status.byte_sync1  = i_rx_byte == SYNC1_BYTE;
    assign o_status.byte_sync2  = i_rx_byte == SYNC2_BYTE;
    assign o_status.len_done    = wp_inc >= LEN_BYTES;
    assign o_status.topic_done  = wp_inc >= HDR_BYTES;
    assign o_status.msg_last    = (msg_room ? wp_inc : r_wp) >= r_msg_end;
    assign o_status.len_zero    = r_msg_len == 8'd0;
    assign o_status.topic_motor = r_topic == r_motor_topic;
    assign o_status.scan_done   = r_pos >= r_msg_end;
    assign o_status.out_valid   = r_out_valid;

    assign o_ev_valid        = r_out_valid;
    assign o_event_kind      = r_ev_kind;
    assign o_left_direction  = r_ev_ld;
    assign o_right_direction = r_ev_rd;
    assign o_left_pwm        = r_ev_lp;
    assign o_right_pwm       = r_ev_rp;

endmodule

@@ rtl/core/sfmcp_ctrl.sv @@
// Controller: frame parse phase and the motor command scan sequencer.
module sfmcp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    input  sfmcp_pkg::t_status i_status,
    output sfmcp_pkg::t_cmd    o_cmd
);

    import sfmcp_pkg::*;

    localparam logic [2:0] PH_SYNC1  = 3'd0;
    localparam logic [2:0] PH_SYNC2  = 3'd1;
    localparam logic [2:0] PH_LEN    = 3'd2;
    localparam logic [2:0] PH_LENCHK = 3'd3;
    localparam logic [2:0] PH_TOPIC  = 3'd4;
    localparam logic [2:0] PH_MSG    = 3'd5;
    localparam logic [2:0] PH_SUM    = 3'd6;

    localparam logic [2:0] SQ_IDLE   = 3'd0;
    localparam logic [2:0] SQ_DIR_L  = 3'd1;
    localparam logic [2:0] SQ_DIR_R  = 3'd2;
    localparam logic [2:0] SQ_SCAN   = 3'd3;
    localparam logic [2:0] SQ_FINISH = 3'd4;

    logic [2:0] r_phase;
    logic [2:0] n_phase;
    logic [2:0] r_seq;
    logic [2:0] n_seq;
    logic       in_fire;

    // the checksum beat may produce a result, so it waits for a free output
    assign o_rx_ready = (r_seq == SQ_IDLE) && !(r_phase == PH_SUM && i_status.out_valid);
    assign in_fire    = i_rx_valid && o_rx_ready;

    always_comb begin
        n_phase = r_phase;
        n_seq   = r_seq;
        o_cmd   = '0;
        o_cmd.rd_kind = RK_NONE;
        if (in_fire) begin
            case (r_phase)
                PH_SYNC1: begin
                    if (i_status.byte_sync1) begin
                        n_phase = PH_SYNC2;
                    end
                end
                PH_SYNC2: begin
                    if (i_status.byte_sync2) begin
                        n_phase        = PH_LEN;
                        o_cmd.wp_clear = 1'b1;
                    end
                end
                PH_LEN: begin
                    o_cmd.wr_len = 1'b1;
                    if (i_status.len_done) begin
                        n_phase = PH_LENCHK;
                    end
                end
                PH_LENCHK: begin
                    n_phase = PH_TOPIC;
                end
                PH_TOPIC: begin
                    o_cmd.wr_topic = 1'b1;
                    if (i_status.topic_done) begin
                        n_phase = i_status.len_zero ? PH_SUM : PH_MSG;
                    end
                end
                PH_MSG: begin
                    o_cmd.wr_msg = 1'b1;
                    if (i_status.msg_last) begin
                        n_phase = PH_SUM;
                    end
                end
                PH_SUM: begin
                    if (i_status.len_zero) begin
                        o_cmd.out_load_short = 1'b1;
                    end else if (i_status.topic_motor) begin
                        n_seq = SQ_DIR_L;
                    end
                    n_phase = PH_SYNC1;
                end
                default: begin
                    n_phase = PH_SYNC1;
                end
            endcase
        end
        case (r_seq)
            SQ_IDLE: ;
            SQ_DIR_L: begin
                o_cmd.scan_init = 1'b1;
                o_cmd.rd_kind   = RK_LDIR;
                n_seq           = SQ_DIR_R;
            end
            SQ_DIR_R: begin
                o_cmd.rd_kind = RK_RDIR;
                n_seq         = SQ_SCAN;
            end
            SQ_SCAN: begin
                if (i_status.scan_done) begin
                    n_seq = SQ_FINISH;
                end else begin
                    o_cmd.rd_kind = RK_DIG;
                end
            end
            SQ_FINISH: begin
                o_cmd.out_load_motor = 1'b1;
                n_seq                = SQ_IDLE;
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_seq   <= SQ_IDLE;
        end else begin
            r_phase <= n_phase;
            r_seq   <= n_seq;
        end
    end

    a_finish_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == SQ_FINISH) |=> (r_seq == SQ_IDLE && r_phase == PH_SYNC1))
        else $error("scan did not end in idle with sync search");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load_short || o_cmd.out_load_motor) |-> !i_status.out_valid)
        else $error("result loaded over a pending beat");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.rd_kind != RK_NONE) |-> !(o_cmd.wr_len || o_cmd.wr_topic || o_cmd.wr_msg))
        else $error("store written during scan");

    a_scan_from_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == SQ_IDLE && n_seq == SQ_DIR_L) |-> (r_phase == PH_SUM && in_fire))
        else $error("scan started outside checksum beat");

endmodule

@@ rtl/core/serial_frame_motor_command_parser_top.sv @@
// Serial frame motor command parser: top level.
// Takes one received byte per beat, hunts for the FF FE sync pair, stores
// length, topic and message bytes, and acts on the checksum byte (not checked).
// Every byte except a checksum byte is accepted whenever no scan runs. An
// empty frame yields a stop or topic-request event on its checksum beat. A
// motor frame's checksum beat starts a scan of the stored ASCII text through
// the frame store's single read port, one byte per cycle with registered
// read data; the input stalls until the scan ends. Bytes beyond BUFFER_DEPTH
// are dropped and read as zero. A checksum beat is held off while an earlier
// event still waits on the output.
module serial_frame_motor_command_parser_top #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sfmcp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfmcp_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                             i_rx_valid,
    output logic                             o_rx_ready,
    input  logic [7:0]                       i_rx_byte,
    output logic                             o_ev_valid,
    input  logic                             i_ev_ready,
    output logic [1:0]                       o_event_kind,
    output logic [7:0]                       o_left_direction,
    output logic [7:0]                       o_right_direction,
    output logic [15:0]                      o_left_pwm,
    output logic [15:0]                      o_right_pwm
);

    import sfmcp_pkg::*;

    t_cmd    cmd;
    t_status status;

    sfmcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sfmcp_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_rx_byte         (i_rx_byte),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_ev_ready        (i_ev_ready),
        .o_ev_valid        (o_ev_valid),
        .o_event_kind      (o_event_kind),
        .o_left_direction  (o_left_direction),
        .o_right_direction (o_right_direction),
        .o_left_pwm        (o_left_pwm),
        .o_right_pwm       (o_right_pwm)
    );

endmodule
